>>> sv/srt_pkg.sv
// Shared types and constants for the swing reversal tracker.
// No dependencies; used by swing_reversal_tracker_top.
`timescale 1ns / 1ps
`default_nettype none

package srt_pkg;

  localparam int IDX_W   = 32;
  localparam int KIND_W  = 3;
  localparam int CFG_W   = 7;

  typedef logic [KIND_W-1:0] kind_t;

  localparam kind_t EV_NONE      = 3'd0;
  localparam kind_t EV_LOW_PEAK  = 3'd1;
  localparam kind_t EV_HIGH_PEAK = 3'd2;
  localparam kind_t EV_HIGH_REV  = 3'd3;
  localparam kind_t EV_LOW_REV   = 3'd4;

  typedef enum logic [1:0] {
    MODE_INIT      = 2'd0,
    MODE_SEEK_HIGH = 2'd1,
    MODE_SEEK_LOW  = 2'd2
  } mode_e;

  typedef enum logic [1:0] {
    ST_IDLE   = 2'd0,
    ST_SCAN   = 2'd1,
    ST_COMMIT = 2'd2
  } state_e;

endpackage

`default_nettype wire

>>> sv/srt_cell.sv
// One cell of the window row: holds one prior bar's high and low and folds
// them into the passing max/min token. No package dependencies.
`timescale 1ns / 1ps
`default_nettype none

module srt_cell #(
  parameter int PW = 32,
  parameter int CW = 7
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          shift_i,
  input  wire logic [PW-1:0] sh_high_i,
  input  wire logic [PW-1:0] sh_low_i,
  output logic      [PW-1:0] sh_high_o,
  output logic      [PW-1:0] sh_low_o,
  input  wire logic          tok_valid_i,
  input  wire logic [CW-1:0] tok_rem_i,
  input  wire logic [PW-1:0] tok_max_i,
  input  wire logic [PW-1:0] tok_min_i,
  output logic               tok_valid_o,
  output logic      [CW-1:0] tok_rem_o,
  output logic      [PW-1:0] tok_max_o,
  output logic      [PW-1:0] tok_min_o
);

  logic [PW-1:0] st_high_q, st_low_q;
  logic          tok_valid_q;
  logic [CW-1:0] tok_rem_q, tok_rem_d;
  logic [PW-1:0] tok_max_q, tok_max_d, tok_min_q, tok_min_d;
  logic          take;

  always_comb begin
    take      = (tok_rem_i != '0);
    tok_rem_d = take ? tok_rem_i - CW'(1) : tok_rem_i;
    tok_max_d = (take && (st_high_q > tok_max_i)) ? st_high_q : tok_max_i;
    tok_min_d = (take && (st_low_q < tok_min_i)) ? st_low_q : tok_min_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_valid_q <= 1'b0;
    end else begin
      tok_valid_q <= tok_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      st_high_q <= sh_high_i;
      st_low_q  <= sh_low_i;
    end
    if (tok_valid_i) begin
      tok_rem_q <= tok_rem_d;
      tok_max_q <= tok_max_d;
      tok_min_q <= tok_min_d;
    end
  end

  assign sh_high_o   = st_high_q;
  assign sh_low_o    = st_low_q;
  assign tok_valid_o = tok_valid_q;
  assign tok_rem_o   = tok_rem_q;
  assign tok_max_o   = tok_max_q;
  assign tok_min_o   = tok_min_q;

endmodule

`default_nettype wire

>>> sv/swing_reversal_tracker_top.sv
// Flow: a bar is accepted only while idle; the max/min token then walks the
// cell row one cell per cycle, and the result is committed once the output
// is not stalled. No new bar is taken until the previous one is committed.
// Reset: asynchronous, active low; clears mode, counters, period (to 1)
// and handshake state. Window cell contents are not cleared.
// Top level of the swing reversal tracker; uses srt_pkg and srt_cell.
`timescale 1ns / 1ps
`default_nettype none

module swing_reversal_tracker_top #(
  parameter int MAX_PERIOD  = 64,
  parameter int PRICE_WIDTH = 32
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      cfg_we_i,
  input  wire logic [srt_pkg::CFG_W-1:0] cfg_wdata_i,
  input  wire logic                      in_valid_i,
  output logic                           in_stall_o,
  input  wire logic [PRICE_WIDTH-1:0]    open_price_i,
  input  wire logic [PRICE_WIDTH-1:0]    high_price_i,
  input  wire logic [PRICE_WIDTH-1:0]    low_price_i,
  output logic                           out_valid_o,
  input  wire logic                      out_stall_i,
  output logic [srt_pkg::IDX_W-1:0]      bar_index_o,
  output logic [srt_pkg::KIND_W-1:0]     event_kind_o,
  output logic [PRICE_WIDTH-1:0]         extreme_value_o,
  output logic [PRICE_WIDTH-1:0]         leg_value_o,
  output logic                           cleared_valid_o,
  output logic [srt_pkg::IDX_W-1:0]      cleared_index_o
);

  localparam int PW = PRICE_WIDTH;
  localparam int N  = MAX_PERIOD;
  localparam int CW = $clog2(MAX_PERIOD + 1);
  localparam int IW = srt_pkg::IDX_W;

  srt_pkg::state_e state_q, state_d;
  srt_pkg::mode_e  mode_q, mode_d;

  logic [srt_pkg::CFG_W-1:0] period_q;
  logic [CW-1:0]             p_eff;
  logic [CW-1:0]             fill_q;
  logic [IW-1:0]             bar_count_q, last_peak_q, last_peak_d;
  logic [PW-1:0]             swing_ext_q, swing_ext_d;
  logic [PW-1:0]             open_q, high_q, low_q;
  logic [PW-1:0]             res_max_q, res_min_q;

  logic out_valid_q;
  logic [IW-1:0]             out_idx_q, out_cidx_q, out_cidx_d;
  srt_pkg::kind_t            out_kind_q, out_kind_d;
  logic [PW-1:0]             out_ext_q, out_ext_d, out_leg_q, out_leg_d;
  logic                      out_cv_q, out_cv_d;

  logic in_acc, out_free, launch, capture, commit;

  logic          tok_v   [0:N];
  logic [CW-1:0] tok_rem [0:N];
  logic [PW-1:0] tok_max [0:N];
  logic [PW-1:0] tok_min [0:N];
  logic [PW-1:0] sh_high [0:N];
  logic [PW-1:0] sh_low  [0:N];

  // effective window length
  always_comb begin
    if (period_q == '0) begin
      p_eff = CW'(1);
    end else if (32'(period_q) > 32'(MAX_PERIOD)) begin
      p_eff = CW'(MAX_PERIOD);
    end else begin
      p_eff = CW'(period_q);
    end
  end

  assign in_acc   = in_valid_i && !in_stall_o;
  assign out_free = !out_valid_q || !out_stall_i;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      srt_pkg::ST_IDLE: begin
        if (in_valid_i) state_d = srt_pkg::ST_SCAN;
      end
      srt_pkg::ST_SCAN: begin
        if (tok_v[N]) state_d = srt_pkg::ST_COMMIT;
      end
      srt_pkg::ST_COMMIT: begin
        if (out_free) state_d = srt_pkg::ST_IDLE;
      end
      default: state_d = srt_pkg::ST_IDLE;
    endcase
  end

  // fsm outputs
  always_comb begin
    in_stall_o = 1'b1;
    launch     = 1'b0;
    capture    = 1'b0;
    commit     = 1'b0;
    case (state_q)
      srt_pkg::ST_IDLE: begin
        in_stall_o = 1'b0;
        launch     = in_valid_i;
      end
      srt_pkg::ST_SCAN:   capture = tok_v[N];
      srt_pkg::ST_COMMIT: commit  = out_free;
      default: ;
    endcase
  end

  // cell row
  assign tok_v[0]   = launch;
  assign tok_rem[0] = p_eff;
  assign tok_max[0] = '0;
  assign tok_min[0] = '1;
  assign sh_high[0] = high_q;
  assign sh_low[0]  = low_q;

  for (genvar k = 0; k < N; k++) begin : g_cell
    srt_cell #(
      .PW (PW),
      .CW (CW)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .shift_i     (commit),
      .sh_high_i   (sh_high[k]),
      .sh_low_i    (sh_low[k]),
      .sh_high_o   (sh_high[k+1]),
      .sh_low_o    (sh_low[k+1]),
      .tok_valid_i (tok_v[k]),
      .tok_rem_i   (tok_rem[k]),
      .tok_max_i   (tok_max[k]),
      .tok_min_i   (tok_min[k]),
      .tok_valid_o (tok_v[k+1]),
      .tok_rem_o   (tok_rem[k+1]),
      .tok_max_o   (tok_max[k+1]),
      .tok_min_o   (tok_min[k+1])
    );
  end

  // decision
  logic          fill_ok, hi_rev, lo_rev;
  logic [PW-1:0] hi_leg, lo_leg;

  always_comb begin
    fill_ok = (fill_q >= p_eff);
    hi_rev  = fill_ok && ((open_q >= res_max_q) || (high_q >= res_max_q));
    hi_leg  = (open_q >= res_max_q) ? open_q : res_max_q;
    lo_rev  = fill_ok && ((open_q <= res_min_q) || (low_q <= res_min_q));
    lo_leg  = (open_q <= res_min_q) ? open_q : res_min_q;

    mode_d      = mode_q;
    swing_ext_d = swing_ext_q;
    last_peak_d = last_peak_q;
    out_kind_d  = srt_pkg::EV_NONE;
    out_ext_d   = '0;
    out_leg_d   = '0;
    out_cv_d    = 1'b0;
    out_cidx_d  = '0;

    case (mode_q)
      srt_pkg::MODE_SEEK_HIGH: begin
        if (low_q < swing_ext_q) begin
          out_kind_d  = srt_pkg::EV_LOW_PEAK;
          out_ext_d   = low_q;
          out_cv_d    = 1'b1;
          out_cidx_d  = last_peak_q;
          swing_ext_d = low_q;
          last_peak_d = bar_count_q;
        end else if (hi_rev) begin
          out_kind_d  = srt_pkg::EV_HIGH_REV;
          out_ext_d   = high_q;
          out_leg_d   = hi_leg;
          swing_ext_d = high_q;
          mode_d      = srt_pkg::MODE_SEEK_LOW;
          last_peak_d = bar_count_q;
        end
      end
      srt_pkg::MODE_SEEK_LOW: begin
        if (high_q > swing_ext_q) begin
          out_kind_d  = srt_pkg::EV_HIGH_PEAK;
          out_ext_d   = high_q;
          out_cv_d    = 1'b1;
          out_cidx_d  = last_peak_q;
          swing_ext_d = high_q;
          last_peak_d = bar_count_q;
        end else if (lo_rev) begin
          out_kind_d  = srt_pkg::EV_LOW_REV;
          out_ext_d   = low_q;
          out_leg_d   = lo_leg;
          swing_ext_d = low_q;
          mode_d      = srt_pkg::MODE_SEEK_HIGH;
          last_peak_d = bar_count_q;
        end
      end
      default: begin
        if (hi_rev) begin
          out_kind_d  = srt_pkg::EV_HIGH_REV;
          out_ext_d   = high_q;
          out_leg_d   = hi_leg;
          swing_ext_d = high_q;
          mode_d      = srt_pkg::MODE_SEEK_LOW;
          last_peak_d = bar_count_q;
        end else if (lo_rev) begin
          out_kind_d  = srt_pkg::EV_LOW_REV;
          out_ext_d   = low_q;
          out_leg_d   = lo_leg;
          swing_ext_d = low_q;
          mode_d      = srt_pkg::MODE_SEEK_HIGH;
          last_peak_d = bar_count_q;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= srt_pkg::ST_IDLE;
      mode_q      <= srt_pkg::MODE_INIT;
      period_q    <= srt_pkg::CFG_W'(1);
      fill_q      <= '0;
      bar_count_q <= '0;
      last_peak_q <= '1;
      swing_ext_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) period_q <= cfg_wdata_i;
      if (commit) begin
        mode_q      <= mode_d;
        swing_ext_q <= swing_ext_d;
        last_peak_q <= last_peak_d;
        bar_count_q <= bar_count_q + IW'(1);
        if (fill_q != CW'(MAX_PERIOD)) fill_q <= fill_q + CW'(1);
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      open_q <= open_price_i;
      high_q <= high_price_i;
      low_q  <= low_price_i;
    end
    if (capture) begin
      res_max_q <= tok_max[N];
      res_min_q <= tok_min[N];
    end
    if (commit) begin
      out_idx_q  <= bar_count_q;
      out_kind_q <= out_kind_d;
      out_ext_q  <= out_ext_d;
      out_leg_q  <= out_leg_d;
      out_cv_q   <= out_cv_d;
      out_cidx_q <= out_cidx_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign bar_index_o     = out_idx_q;
  assign event_kind_o    = out_kind_q;
  assign extreme_value_o = out_ext_q;
  assign leg_value_o     = out_leg_q;
  assign cleared_valid_o = out_cv_q;
  assign cleared_index_o = out_cidx_q;

endmodule

`default_nettype wire
